// File: sv/hsio_pkg.sv
// ----------------------------------------------------------------------------
// hsio_pkg
// Shared constants and types of the heap sort index order unit.
// ----------------------------------------------------------------------------
package hsio_pkg;

  localparam int unsigned IDX_W         = 6;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_RD,
    ST_BLD_CHK,
    ST_BLD_WR,
    ST_SIFT_RD,
    ST_SIFT_LD,
    ST_LV_RD,
    ST_LV_PICK,
    ST_LV_CMP,
    ST_SIFT_END,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_OUT_RD,
    ST_OUT_V
  } hsio_state_e;

endpackage

// File: sv/hsio_cmp.sv
// ----------------------------------------------------------------------------
// hsio_cmp
// Shared key comparator: tells whether key a ranks behind key b.
// ----------------------------------------------------------------------------
module hsio_cmp #(
  parameter int unsigned KEY_WIDTH = hsio_pkg::KEY_WIDTH_DEF
) (
  input  logic [KEY_WIDTH-1:0] a_i,
  input  logic [KEY_WIDTH-1:0] b_i,
  input  logic                 desc_i,
  output logic                 behind_o
);

  // In descending order a larger key ranks behind the smaller one in heap terms.
  assign behind_o = desc_i ? ($signed(a_i) > $signed(b_i))
                           : ($signed(a_i) < $signed(b_i));

endmodule

// File: sv/hsio_heap_mem.sv
// ----------------------------------------------------------------------------
// hsio_heap_mem
// Heap storage of index and key pairs: one write port, two registered reads.
// ----------------------------------------------------------------------------
module hsio_heap_mem #(
  parameter int unsigned DEPTH = hsio_pkg::MAX_ITEMS_DEF,
  parameter int unsigned DW    = hsio_pkg::IDX_W + hsio_pkg::KEY_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [DW-1:0] rdata0_o,
  output logic [DW-1:0] rdata1_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// File: sv/heap_sort_index_order_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_index_order_unit
// Loads keys with order indices, heap-sorts the indices by key, streams them.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle while s_axis_tready_o is high. The word with
// tlast, or the MAX_ITEMS-th word, closes the set; the block then drops ready,
// builds the heap, heap-sorts with one comparator and one heap memory, and
// streams one result word per item. Each sift-down level reads the children,
// picks a child, then compares and writes back; each sift-down also fetches
// its start entry and writes the last one back. A full set of 64 items walks
// 321 levels in 95 sift-downs. The single comparator and the heap memory
// ports set the pace of the sort.
module heap_sort_index_order_unit #(
  parameter int unsigned MAX_ITEMS = hsio_pkg::MAX_ITEMS_DEF,
  parameter int unsigned KEY_WIDTH = hsio_pkg::KEY_WIDTH_DEF,
  localparam int unsigned TDW = ((KEY_WIDTH + hsio_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,       // sort_descending
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [TDW-1:0] s_axis_tdata_i,    // key_value, order_index, zero pad
  input  logic           s_axis_tlast_i,    // last_item
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [TDW-1:0] m_axis_tdata_o,    // sorted_index, sorted_key, zero pad
  output logic           m_axis_tlast_o,    // last_result
  output logic           m_axis_tuser_o     // index_error
);

  localparam int unsigned IW = hsio_pkg::IDX_W;
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PW = AW + 2;
  localparam int unsigned DW = IW + KEY_WIDTH;

  hsio_pkg::hsio_state_e state_q, state_d;

  logic                 desc_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        i_q, i_d;
  logic [CW-1:0]        m_q, m_d;
  logic [CW-1:0]        lim_q, lim_d;
  logic [PW-1:0]        j_q, j_d;
  logic [PW-1:0]        k_q, k_d;
  logic                 err_q, err_d;
  logic                 ph2_q, ph2_d;
  logic [IW-1:0]        idxv_q, idxv_d;
  logic [DW-1:0]        jval_q, jval_d;
  logic [DW-1:0]        child_q, child_d;

  logic [KEY_WIDTH-1:0] key_mem_q [MAX_ITEMS];
  logic [IW-1:0]        idx_mem_q [MAX_ITEMS];
  logic [KEY_WIDTH-1:0] key_rd_q;
  logic [IW-1:0]        idx_rd_q;
  logic [AW-1:0]        key_raddr;

  logic                 hm_we;
  logic [AW-1:0]        hm_waddr;
  logic [DW-1:0]        hm_wdata;
  logic [AW-1:0]        hm_raddr0, hm_raddr1;
  logic [DW-1:0]        hm_rd0, hm_rd1;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 behind;

  logic                 in_acc;
  logic [PW-1:0]        jm1, km1, k2, mm1;
  logic                 idx_bad;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign jm1    = j_q - PW'(1);
  assign km1    = k_q - PW'(1);
  assign k2     = k_q << 1;
  assign mm1    = PW'(m_q) - PW'(1);
  assign idx_bad = (IW + 1)'(idx_rd_q) >= (IW + 1)'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b1;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  // Load-side stores, indexed by load position.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_mem_q[cnt_q[AW-1:0]] <= s_axis_tdata_i[KEY_WIDTH-1:0];
      idx_mem_q[cnt_q[AW-1:0]] <= s_axis_tdata_i[KEY_WIDTH +: IW];
    end
    idx_rd_q <= idx_mem_q[i_q];
    key_rd_q <= key_mem_q[key_raddr];
  end

  hsio_heap_mem #(
    .DEPTH (MAX_ITEMS),
    .DW    (DW)
  ) u_heap (
    .clk_i    (clk_i),
    .we_i     (hm_we),
    .waddr_i  (hm_waddr),
    .wdata_i  (hm_wdata),
    .raddr0_i (hm_raddr0),
    .raddr1_i (hm_raddr1),
    .rdata0_o (hm_rd0),
    .rdata1_o (hm_rd1)
  );

  assign cmp_a = (state_q == hsio_pkg::ST_LV_PICK) ? hm_rd0[DW-1:IW] : jval_q[DW-1:IW];
  assign cmp_b = (state_q == hsio_pkg::ST_LV_PICK) ? hm_rd1[DW-1:IW] : child_q[DW-1:IW];

  hsio_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .desc_i   (desc_q),
    .behind_o (behind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsio_pkg::ST_LOAD;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    m_q     <= m_d;
    lim_q   <= lim_d;
    j_q     <= j_d;
    k_q     <= k_d;
    ph2_q   <= ph2_d;
    idxv_q  <= idxv_d;
    jval_q  <= jval_d;
    child_q <= child_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    m_d       = m_q;
    lim_d     = lim_q;
    j_d       = j_q;
    k_d       = k_q;
    err_d     = err_q;
    ph2_d     = ph2_q;
    idxv_d    = idxv_q;
    jval_d    = jval_q;
    child_d   = child_q;
    key_raddr = idxv_q[AW-1:0];
    hm_we     = 1'b0;
    hm_waddr  = jm1[AW-1:0];
    hm_wdata  = jval_q;
    hm_raddr0 = i_q;
    hm_raddr1 = i_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    unique case (state_q)
      hsio_pkg::ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        i_d = '0;
        if (in_acc) begin
          cnt_d = cnt_q + CW'(1);
          if (s_axis_tlast_i || (cnt_q + CW'(1) == CW'(MAX_ITEMS))) begin
            state_d = hsio_pkg::ST_BLD_RD;
          end
        end
      end
      hsio_pkg::ST_BLD_RD: begin
        state_d = hsio_pkg::ST_BLD_CHK;
      end
      hsio_pkg::ST_BLD_CHK: begin
        // An index past the loaded count points at its own position.
        if (idx_bad) begin
          idxv_d = IW'(i_q);
          err_d  = 1'b1;
        end else begin
          idxv_d = idx_rd_q;
        end
        key_raddr = idx_bad ? i_q : idx_rd_q[AW-1:0];
        state_d   = hsio_pkg::ST_BLD_WR;
      end
      hsio_pkg::ST_BLD_WR: begin
        hm_we    = 1'b1;
        hm_waddr = i_q;
        hm_wdata = {key_rd_q, idxv_q};
        if (CW'(i_q) == cnt_q - CW'(1)) begin
          i_d = '0;
          if (cnt_q > CW'(1)) begin
            m_d     = cnt_q >> 1;
            lim_d   = cnt_q;
            ph2_d   = 1'b0;
            state_d = hsio_pkg::ST_SIFT_RD;
          end else begin
            state_d = hsio_pkg::ST_OUT_RD;
          end
        end else begin
          i_d     = i_q + AW'(1);
          state_d = hsio_pkg::ST_BLD_RD;
        end
      end
      hsio_pkg::ST_SIFT_RD: begin
        hm_raddr0 = mm1[AW-1:0];
        state_d   = hsio_pkg::ST_SIFT_LD;
      end
      hsio_pkg::ST_SIFT_LD: begin
        jval_d = hm_rd0;
        j_d    = PW'(m_q);
        k_d    = PW'(m_q) << 1;
        state_d = ((PW'(m_q) << 1) <= PW'(lim_q)) ? hsio_pkg::ST_LV_RD
                                                   : hsio_pkg::ST_SIFT_END;
      end
      hsio_pkg::ST_LV_RD: begin
        hm_raddr0 = km1[AW-1:0];
        hm_raddr1 = k_q[AW-1:0];
        state_d   = hsio_pkg::ST_LV_PICK;
      end
      hsio_pkg::ST_LV_PICK: begin
        if ((k_q < PW'(lim_q)) && behind) begin
          child_d = hm_rd1;
          k_d     = k_q + PW'(1);
        end else begin
          child_d = hm_rd0;
        end
        state_d = hsio_pkg::ST_LV_CMP;
      end
      hsio_pkg::ST_LV_CMP: begin
        // The walk goes on to the bottom whether or not the entries swap.
        hm_we = 1'b1;
        if (behind) begin
          hm_wdata = child_q;
        end else begin
          hm_wdata = jval_q;
          jval_d   = child_q;
        end
        j_d = k_q;
        k_d = k2;
        state_d = (k2 <= PW'(lim_q)) ? hsio_pkg::ST_LV_RD : hsio_pkg::ST_SIFT_END;
      end
      hsio_pkg::ST_SIFT_END: begin
        hm_we = 1'b1;
        if (!ph2_q) begin
          if (m_q > CW'(1)) begin
            m_d     = m_q - CW'(1);
            state_d = hsio_pkg::ST_SIFT_RD;
          end else begin
            ph2_d   = 1'b1;
            lim_d   = cnt_q - CW'(1);
            state_d = hsio_pkg::ST_SWAP_RD;
          end
        end else if (lim_q > CW'(1)) begin
          lim_d   = lim_q - CW'(1);
          state_d = hsio_pkg::ST_SWAP_RD;
        end else begin
          i_d     = '0;
          state_d = hsio_pkg::ST_OUT_RD;
        end
      end
      hsio_pkg::ST_SWAP_RD: begin
        hm_raddr0 = '0;
        hm_raddr1 = lim_q[AW-1:0];
        state_d   = hsio_pkg::ST_SWAP_WR;
      end
      hsio_pkg::ST_SWAP_WR: begin
        // The old root goes to the end; the last entry sifts down from the root.
        hm_we    = 1'b1;
        hm_waddr = lim_q[AW-1:0];
        hm_wdata = hm_rd0;
        jval_d   = hm_rd1;
        j_d      = PW'(1);
        k_d      = PW'(2);
        state_d  = (PW'(2) <= PW'(lim_q)) ? hsio_pkg::ST_LV_RD : hsio_pkg::ST_SIFT_END;
      end
      hsio_pkg::ST_OUT_RD: begin
        state_d = hsio_pkg::ST_OUT_V;
      end
      hsio_pkg::ST_OUT_V: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (CW'(i_q) == cnt_q - CW'(1)) begin
            cnt_d   = '0;
            err_d   = 1'b0;
            i_d     = '0;
            state_d = hsio_pkg::ST_LOAD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = hsio_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = hsio_pkg::ST_LOAD;
      end
    endcase
  end

  assign m_axis_tdata_o = TDW'(hm_rd0);
  assign m_axis_tlast_o = (CW'(i_q) == cnt_q - CW'(1));
  assign m_axis_tuser_o = err_q;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while a result word is shown");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_out_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (CW'(i_q) < cnt_q))
    else $error("result rank beyond loaded count");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("load not closed after last word");
`endif

endmodule

// File: tb/tb_heap_sort_index_order_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sort index order unit testbench
// Streams sets of keyed order indices into the unit, predicts the sorted
// output of every set in a scoreboard and checks each result word against it.
// ----------------------------------------------------------------------------
class argsort_board;
  logic signed [31:0] keys[$];
  logic [5:0]         idxs[$];
  bit                 descending = 1'b1;
  logic [39:0]        sorted_q[$];
  int                 failures = 0;

  function automatic bit ranks_before(logic signed [31:0] a, logic signed [31:0] b);
    // True when key a must move below key b in the heap for this direction.
    return descending ? (a > b) : (a < b);
  endfunction

  function automatic void sift(int m, int n);
    int j;
    int k;
    logic [5:0] t;
    j = m;
    k = m * 2;
    while (k <= n) begin
      if (k < n && ranks_before(keys[idxs[k-1]], keys[idxs[k]])) k++;
      if (ranks_before(keys[idxs[j-1]], keys[idxs[k-1]])) begin
        t = idxs[j-1];
        idxs[j-1] = idxs[k-1];
        idxs[k-1] = t;
      end
      j = k;
      k *= 2;
    end
  endfunction

  function automatic void note_word(logic signed [31:0] key, logic [5:0] idx, bit last);
    int n;
    bit err;
    logic [5:0] t;
    keys.push_back(key);
    idxs.push_back(idx);
    if (!(last || keys.size() >= 64)) return;
    n = keys.size();
    err = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (idxs[i] >= n) begin
        idxs[i] = 6'(i);
        err = 1'b1;
      end
    end
    for (int j = n / 2; j > 0; j--) sift(j, n);
    for (int j = n - 1; j > 0; j--) begin
      t = idxs[0];
      idxs[0] = idxs[j];
      idxs[j] = t;
      sift(1, j);
    end
    for (int i = 0; i < n; i++)
      sorted_q.push_back({err, (i == n - 1) ? 1'b1 : 1'b0, keys[idxs[i]], idxs[i]});
    keys.delete();
    idxs.delete();
  endfunction

  function automatic void check_word(logic [5:0] idx, logic [31:0] key, bit last, bit err);
    logic [39:0] e;
    if (sorted_q.size() == 0) begin
      $error("unexpected result word: index %0d key %h", idx, key);
      failures++;
      return;
    end
    e = sorted_q.pop_front();
    if (idx !== e[5:0]) begin
      $error("sorted_index expected %0d actual %0d", e[5:0], idx);
      failures++;
    end
    if (key !== e[37:6]) begin
      $error("sorted_key expected %h actual %h", e[37:6], key);
      failures++;
    end
    if (last !== e[38]) begin
      $error("last_result expected %0b actual %0b", e[38], last);
      failures++;
    end
    if (err !== e[39]) begin
      $error("index_error expected %0b actual %0b", e[39], err);
      failures++;
    end
  endfunction
endclass

module tb_heap_sort_index_order_unit;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  argsort_board board = new();
  int  hold_off = 0;
  int  sink_wait = 0;
  bit  sink_go = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  heap_sort_index_order_unit u_top (.*);

  // Send one word, idling first for a random number of cycles when gaps is set. The word stays
  // offered after its acceptance until the next word or an idle stretch.
  task automatic send_word(logic signed [31:0] key, logic [5:0] idx, bit last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, idx, key};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_word(key, idx, last);
  endtask

  task automatic send_set(int n, int mode);
    logic signed [31:0] key;
    logic [5:0] idx;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: key = $urandom_range(0, 3) - 2;
        1: key = ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        default: key = $urandom();
      endcase
      // Mostly a valid permutation-like index, sometimes out of range.
      if (mode == 1 && $urandom_range(0, 9) == 0) idx = $urandom_range(0, 63);
      else idx = $urandom_range(0, n - 1);
      send_word(key, idx, i == n - 1, 1'b1);
    end
  endtask

  task automatic set_direction(bit d);
    s_axis_tvalid_i <= 1'b0;
    wait (board.sorted_q.size() == 0);
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.descending = d;
  endtask

  // Result side: a random wait before each word once sink_go is set, plus hold-offs on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        board.check_word(m_axis_tdata_o[5:0], m_axis_tdata_o[37:6],
                         m_axis_tlast_o, m_axis_tuser_o);
        sink_wait = sink_go ? $urandom_range(0, 16) : 0;
      end
      if (hold_off > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_off--;
      end else if (sink_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extreme keys, ties, out-of-range and duplicate indices.
    send_word(32'sh7fffffff, 6'd1, 1'b0, 1'b0);
    send_word(32'sh80000000, 6'd0, 1'b0, 1'b0);
    send_word(32'sh00000000, 6'd63, 1'b0, 1'b0);
    send_word(32'sh00000000, 6'd2, 1'b1, 1'b0);
    send_word(-32'sd1, 6'd1, 1'b0, 1'b0);
    send_word(32'sd1, 6'd1, 1'b1, 1'b0);
    send_word(32'sh5555aaaa, 6'd0, 1'b1, 1'b0);
    set_direction(1'b0);
    send_word(32'shaaaa5555, 6'd2, 1'b0, 1'b0);
    send_word(32'sh7fffffff, 6'd0, 1'b0, 1'b0);
    send_word(32'sh80000000, 6'd1, 1'b0, 1'b0);
    send_word(32'sh00000005, 6'd42, 1'b1, 1'b0);
    // Full set with no tlast closes at the 64th word; receiver holds off.
    hold_off = 2500;
    for (int i = 0; i < 64; i++)
      send_word($urandom(), 6'(63 - i), 1'b0, 1'b0);
    sink_go = 1'b1;
    sent = 76;
    while (sent < 300) begin
      automatic int n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64)
                                                    : $urandom_range(1, 12);
      if ($urandom_range(0, 5) == 0) set_direction($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) hold_off = 200;
      send_set(n, 1);
      sent += n;
    end
    set_direction(1'b1);
    send_set(5, 1);
    s_axis_tvalid_i <= 1'b0;
    wait (board.sorted_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
